// File: rtl/sorted_list_insert_remove_assert.svh
// Assertion macros for the sorted list insert/remove block.
// Used by the RTL files that assert; no other dependencies.
`ifndef SORTED_LIST_INSERT_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication
`define SLRI_ASSERT_IMP(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("slri assertion failed");

// next-cycle implication
`define SLRI_ASSERT_NXT(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("slri assertion failed");

`endif

// File: rtl/slri_pkg.sv
// Package for the sorted list insert/remove block: sizes, codes, FSM and
// controller/datapath interface types. No dependencies.
package slri_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request fields
        logic do_insert;  // commit shifted-up row
        logic do_remove;  // commit shifted-down row
        logic report;     // emit result strobe
        logic success;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic action;
        logic full;
        logic found;
    } status_t;

endpackage

// File: rtl/sorted_list_insert_remove.sv
// Sorted list insert/remove: bounded ascending store of signed 32-bit values,
// duplicates allowed. A request (start while busy is low) inserts value
// (action 0) before the first stored value not smaller, or removes one
// occurrence of it (action 1). Busy is high for the cycle after the accept,
// while the row of compare/shift cells settles and commits; the next cycle
// carries done for exactly one cycle with success (0 on full store or value
// absent) and count, the number of values stored after the request. The
// receiver cannot stall the result; a new request may be accepted in the
// same cycle done is shown. Reset empties the store at once. Depends on
// slri_pkg, slri_ctrl, slri_datapath.
`include "sorted_list_insert_remove_assert.svh"

module sorted_list_insert_remove (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic signed [slri_pkg::VAL_W-1:0] value,
    output logic                              done,
    output logic                              success,
    output logic [slri_pkg::COUNT_W-1:0]      count
);

    slri_pkg::cmd_t    cmd;
    slri_pkg::status_t status;

    slri_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    slri_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .action  (action),
        .value   (value),
        .done    (done),
        .success (success),
        .count   (count)
    );

    `SLRI_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SLRI_ASSERT_NXT(a_busy_done, clk, rst_n, busy, done && !busy)
    `SLRI_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

endmodule

// File: rtl/slri_datapath.sv
// Datapath: row of compare/shift cells holding the sorted values, count and
// result registers. Depends on slri_pkg and the assertion macro header.
`include "sorted_list_insert_remove_assert.svh"

module slri_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slri_pkg::cmd_t                   cmd,
    output slri_pkg::status_t                status,
    input  logic                             action,
    input  logic signed [slri_pkg::VAL_W-1:0] value,
    output logic                             done,
    output logic                             success,
    output logic [slri_pkg::COUNT_W-1:0]     count
);

    logic signed [slri_pkg::VAL_W-1:0] store_reg [slri_pkg::CAPACITY];
    logic [slri_pkg::CNT_W-1:0]        count_reg;
    logic [slri_pkg::CNT_W-1:0]        count_next;
    logic                              action_reg;
    logic signed [slri_pkg::VAL_W-1:0] value_reg;
    logic                              done_reg;
    logic                              success_reg;

    logic [slri_pkg::CAPACITY-1:0]     lt;
    logic [slri_pkg::CAPACITY-1:0]     hit;
    logic signed [slri_pkg::VAL_W-1:0] ins_val [slri_pkg::CAPACITY];
    logic signed [slri_pkg::VAL_W-1:0] rem_val [slri_pkg::CAPACITY];

    // each cell: valid and smaller than the request value -> stays put
    for (genvar g = 0; g < slri_pkg::CAPACITY; g++) begin : g_cell
        logic valid;
        logic eq;
        assign valid = slri_pkg::CNT_W'(g) < count_reg;
        assign lt[g] = valid && (store_reg[g] < value_reg);
        assign eq    = valid && (store_reg[g] == value_reg);
        if (g == 0) begin : g_first
            assign hit[g]     = eq && !lt[g];
            assign ins_val[g] = lt[g] ? store_reg[g] : value_reg;
        end
        else begin : g_rest
            // first cell not below the value is where it goes or is found
            assign hit[g]     = eq && !lt[g] && lt[g-1];
            assign ins_val[g] = lt[g]   ? store_reg[g] :
                                lt[g-1] ? value_reg    : store_reg[g-1];
        end
        if (g == slri_pkg::CAPACITY - 1) begin : g_last
            assign rem_val[g] = store_reg[g];
        end
        else begin : g_inner
            assign rem_val[g] = lt[g] ? store_reg[g] : store_reg[g+1];
        end
    end

    assign status.action = action_reg;
    assign status.full   = count_reg == slri_pkg::CNT_W'(slri_pkg::CAPACITY);
    assign status.found  = |hit;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            value_reg  <= value;
        end
        if (cmd.report)
        begin
            success_reg <= cmd.success;
        end
        for (int i = 0; i < slri_pkg::CAPACITY; i++)
        begin
            if (cmd.do_insert)
            begin
                store_reg[i] <= ins_val[i];
            end
            else if (cmd.do_remove)
            begin
                store_reg[i] <= rem_val[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.report;
        end
    end

    assign done    = done_reg;
    assign success = success_reg;
    assign count   = slri_pkg::COUNT_W'(count_reg);

    `SLRI_ASSERT_IMP(a_ins_not_full, clk, rst_n, cmd.do_insert, !status.full)
    `SLRI_ASSERT_IMP(a_rem_not_empty, clk, rst_n, cmd.do_remove, count_reg != '0)
    `SLRI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= slri_pkg::CNT_W'(slri_pkg::CAPACITY))
    `SLRI_ASSERT_IMP(a_hit_onehot, clk, rst_n, 1'b1, $onehot0(hit))

endmodule

// File: rtl/slri_ctrl.sv
// Controller FSM: accepts a request, then commits insert or remove and
// reports the result. Depends on slri_pkg.
module slri_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slri_pkg::status_t status,
    output slri_pkg::cmd_t    cmd
);

    slri_pkg::state_t state_reg;
    slri_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slri_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            slri_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = slri_pkg::ST_EXEC;
                end
            end
            slri_pkg::ST_EXEC:
            begin
                busy          = 1'b1;
                cmd.do_insert = (status.action == slri_pkg::ACT_INSERT) && !status.full;
                cmd.do_remove = (status.action == slri_pkg::ACT_REMOVE) && status.found;
                cmd.report    = 1'b1;
                cmd.success   = cmd.do_insert || cmd.do_remove;
                state_next    = slri_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = slri_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
